// ----- sv/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
package slc_pkg;

   localparam int SET_CNT_BITS  = 7;
   localparam int WAY_CNT_BITS  = 4;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SET_COUNT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAY_COUNT = CSR_IDX_BITS'(1);

   localparam logic [SET_CNT_BITS-1:0] SET_COUNT_RST = SET_CNT_BITS'(64);
   localparam logic [WAY_CNT_BITS-1:0] WAY_COUNT_RST = WAY_CNT_BITS'(8);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_BASE,
      ST_SCAN,
      ST_WRITE
   } state_type;

endpackage

// ----- sv/slc_chan_if.sv -----
// ----------------------------------------------------------------------------
// slc channel interfaces
// Valid/ready channels for lookup requests, lookup responses and CSR writes.
// ----------------------------------------------------------------------------
interface slc_req_if #(
   parameter int BLOCK_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [BLOCK_BITS-1:0] block_number;

   modport source (output valid, output block_number, input ready);
   modport sink   (input valid, input block_number, output ready);
endinterface

interface slc_rsp_if #(
   parameter int BLOCK_BITS = 16,
   parameter int SET_BITS   = 6,
   parameter int WAY_BITS   = 3
);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SET_BITS-1:0]   set_index;
   logic [WAY_BITS-1:0]   way_index;
   logic                  evicted;
   logic [BLOCK_BITS-1:0] evicted_block;

   modport source (output valid, output hit, output set_index, output way_index,
                   output evicted, output evicted_block, input ready);
   modport sink   (input valid, input hit, input set_index, input way_index,
                   input evicted, input evicted_block, output ready);
endinterface

interface slc_csr_if
   import slc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  wr_index;
   logic [CSR_DATA_BITS-1:0] wr_data;

   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// ----- sv/slc_mod_unit.sv -----
// ----------------------------------------------------------------------------
// slc_mod_unit
// Restoring remainder unit: one dividend bit per cycle, compare and subtract.
// ----------------------------------------------------------------------------
module slc_mod_unit
   import slc_pkg::*;
#(
   parameter int DIVIDEND_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [SET_CNT_BITS-1:0]  divisor,
   output logic                     done,
   output logic [SET_CNT_BITS-1:0]  remainder
);

   localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] num_ff, num_in;
   logic [SET_CNT_BITS-1:0]  den_ff, den_in;
   logic [SET_CNT_BITS-1:0]  rem_ff, rem_in;
   logic [SET_CNT_BITS:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[cnt_ff]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS - 1);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = SET_CNT_BITS'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[SET_CNT_BITS-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < den_ff)
      else $error("remainder not below divisor");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == '0 |=> done_ff && !busy_ff)
      else $error("last step did not finish");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without work");

endmodule

// ----- sv/set_assoc_lru_cache_lookup.sv -----
// Sequence: the remainder unit takes one block bit a cycle and the scan reads
// one way a cycle from the line memory, which has a read port and a write port.
// Requests: a new request is taken only in idle, after the previous line write;
// that write waits while the response register waits on rsp ready.
// Reset: a clearing pass writes every line empty; no request is taken
// meanwhile, CSR writes are.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative cache tag lookup with least-recently-used replacement.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup
   import slc_pkg::*;
#(
   parameter int MAX_SETS   = 64,
   parameter int MAX_WAYS   = 8,
   parameter int BLOCK_BITS = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic   clock,
   input  logic   reset,
   slc_req_if.sink   req_chan,
   slc_rsp_if.source rsp_chan,
   slc_csr_if.sink   csr_chan
);

   localparam int LINES     = MAX_SETS * MAX_WAYS;
   localparam int ADDR_BITS = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int SET_BITS  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_BITS = $clog2(MAX_WAYS + 1);

   typedef struct packed {
      logic                  valid;
      logic [BLOCK_BITS-1:0] blk;
      logic [STAMP_BITS-1:0] stamp;
   } line_type;

   // configuration
   logic [SET_CNT_BITS-1:0] set_cnt_ff;
   logic [WAY_CNT_BITS-1:0] way_cnt_ff;
   logic [SET_CNT_BITS-1:0] sets_eff;
   logic [WCNT_BITS-1:0]    ways_eff;

   // sequencer
   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [BLOCK_BITS-1:0]   blk_ff, blk_in;
   logic [WCNT_BITS-1:0]    ways_ff, ways_in;
   logic [SET_BITS-1:0]     set_ff, set_in;
   logic [ADDR_BITS-1:0]    base_ff, base_in;
   logic [WCNT_BITS-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [WAY_BITS-1:0]     rd_way_ff, rd_way_in;
   logic [STAMP_BITS-1:0]   acc_ff, acc_in;

   // scan results
   logic                    found_ff, found_in;
   logic [WAY_BITS-1:0]     hit_way_ff, hit_way_in;
   logic                    have_empty_ff, have_empty_in;
   logic [WAY_BITS-1:0]     empty_way_ff, empty_way_in;
   logic                    have_vic_ff, have_vic_in;
   logic [WAY_BITS-1:0]     vic_way_ff, vic_way_in;
   logic [STAMP_BITS-1:0]   vic_stamp_ff, vic_stamp_in;
   logic [BLOCK_BITS-1:0]   vic_blk_ff, vic_blk_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [SET_BITS-1:0]     rsp_set_ff, rsp_set_in;
   logic [WAY_BITS-1:0]     rsp_way_ff, rsp_way_in;
   logic                    rsp_ev_ff, rsp_ev_in;
   logic [BLOCK_BITS-1:0]   rsp_ev_blk_ff, rsp_ev_blk_in;

   // line memory
   line_type                mem [LINES];
   line_type                rd_data_ff;
   line_type                wr_data;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic                    wr_en;

   logic                    req_go;
   logic                    wr_go;
   logic [WAY_BITS-1:0]     chosen;
   logic                    div_done;
   logic [SET_CNT_BITS-1:0] div_rem;

   // ------------------------------------------------------------------ CSR --
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_cnt_ff <= SET_COUNT_RST;
         way_cnt_ff <= WAY_COUNT_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.wr_index)
            CSR_SET_COUNT: set_cnt_ff <= csr_chan.wr_data[SET_CNT_BITS-1:0];
            CSR_WAY_COUNT: way_cnt_ff <= csr_chan.wr_data[WAY_CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (set_cnt_ff == '0) begin
         sets_eff = SET_CNT_BITS'(1);
      end else if (int'(set_cnt_ff) > MAX_SETS) begin
         sets_eff = SET_CNT_BITS'(MAX_SETS);
      end else begin
         sets_eff = set_cnt_ff;
      end
      if (way_cnt_ff == '0) begin
         ways_eff = WCNT_BITS'(1);
      end else if (int'(way_cnt_ff) > MAX_WAYS) begin
         ways_eff = WCNT_BITS'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_BITS'(way_cnt_ff);
      end
   end

   // ------------------------------------------------------- set remainder --
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_go         = req_chan.valid && req_chan.ready;

   slc_mod_unit #(
      .DIVIDEND_BITS (BLOCK_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_go),
      .dividend  (req_chan.block_number),
      .divisor   (sets_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // -------------------------------------------------------------- memory --
   assign rd_addr = base_ff + ADDR_BITS'(iss_cnt_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ----------------------------------------------------------- sequencer --
   assign wr_go = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      if (found_ff) begin
         chosen = hit_way_ff;
      end else if (have_empty_ff) begin
         chosen = empty_way_ff;
      end else begin
         chosen = vic_way_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      blk_in        = blk_ff;
      ways_in       = ways_ff;
      set_in        = set_ff;
      base_in       = base_ff;
      iss_cnt_in    = iss_cnt_ff;
      rd_valid_in   = 1'b0;
      rd_way_in     = rd_way_ff;
      acc_in        = acc_ff;
      found_in      = found_ff;
      hit_way_in    = hit_way_ff;
      have_empty_in = have_empty_ff;
      empty_way_in  = empty_way_ff;
      have_vic_in   = have_vic_ff;
      vic_way_in    = vic_way_ff;
      vic_stamp_in  = vic_stamp_ff;
      vic_blk_in    = vic_blk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_set_in    = rsp_set_ff;
      rsp_way_in    = rsp_way_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_ev_blk_in = rsp_ev_blk_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_BITS'(LINES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_go) begin
               blk_in   = req_chan.block_number;
               ways_in  = ways_eff;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               set_in   = SET_BITS'(div_rem);
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            base_in       = ADDR_BITS'(ADDR_BITS'(set_ff) * ADDR_BITS'(MAX_WAYS));
            iss_cnt_in    = '0;
            found_in      = 1'b0;
            have_empty_in = 1'b0;
            have_vic_in   = 1'b0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (iss_cnt_ff < ways_ff) begin
               rd_valid_in = 1'b1;
               rd_way_in   = WAY_BITS'(iss_cnt_ff);
               iss_cnt_in  = iss_cnt_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (rd_data_ff.valid) begin
                  if (!found_ff && rd_data_ff.blk == blk_ff) begin
                     found_in   = 1'b1;
                     hit_way_in = rd_way_ff;
                  end
                  if (!have_vic_ff || rd_data_ff.stamp < vic_stamp_ff) begin
                     have_vic_in  = 1'b1;
                     vic_way_in   = rd_way_ff;
                     vic_stamp_in = rd_data_ff.stamp;
                     vic_blk_in   = rd_data_ff.blk;
                  end
               end else if (!have_empty_ff) begin
                  have_empty_in = 1'b1;
                  empty_way_in  = rd_way_ff;
               end
               if (rd_way_ff == WAY_BITS'(ways_ff - 1'b1)) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (wr_go) begin
               wr_en         = 1'b1;
               wr_addr       = base_ff + ADDR_BITS'(chosen);
               wr_data.valid = 1'b1;
               wr_data.blk   = blk_ff;
               wr_data.stamp = acc_ff;
               if (acc_ff != '1) begin
                  acc_in = acc_ff + 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = found_ff;
               rsp_set_in    = set_ff;
               rsp_way_in    = chosen;
               rsp_ev_in     = !found_ff && !have_empty_ff;
               rsp_ev_blk_in = (!found_ff && !have_empty_ff) ? vic_blk_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         acc_ff       <= STAMP_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_valid_ff  <= rd_valid_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff        <= blk_in;
      ways_ff       <= ways_in;
      set_ff        <= set_in;
      base_ff       <= base_in;
      iss_cnt_ff    <= iss_cnt_in;
      rd_way_ff     <= rd_way_in;
      found_ff      <= found_in;
      hit_way_ff    <= hit_way_in;
      have_empty_ff <= have_empty_in;
      empty_way_ff  <= empty_way_in;
      have_vic_ff   <= have_vic_in;
      vic_way_ff    <= vic_way_in;
      vic_stamp_ff  <= vic_stamp_in;
      vic_blk_ff    <= vic_blk_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_set_ff    <= rsp_set_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_ev_blk_ff <= rsp_ev_blk_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.set_index     = rsp_set_ff;
   assign rsp_chan.way_index     = rsp_way_ff;
   assign rsp_chan.evicted       = rsp_ev_ff;
   assign rsp_chan.evicted_block = rsp_ev_blk_ff;

   // ---------------------------------------------------------- assertions --
   a_write_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE && wr_go |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("response beat not loaded on line write");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == ST_SCAN)
      else $error("memory read data outside scan");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_ff))
      else $error("hit with eviction");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ev_ff |-> rsp_ev_blk_ff == '0)
      else $error("evicted block set without eviction");

   a_counter_nonzero: assert property (@(posedge clock) disable iff (reset)
      acc_ff != '0)
      else $error("access counter wrapped");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache lookup. A short
// directed table exercises fills, hits, evictions and the count-register
// corners. Random phases follow, each under its own set and way counts, with
// bursty requests and a stalling response side. Every response beat is compared
// field by field, against the table's result for checked rows, else against an in-bench model of the tag store.
// ----------------------------------------------------------------------------
module tb_top
   import slc_pkg::*;
();

   localparam int N_SETS = 64;
   localparam int N_WAYS = 8;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 137;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = CSR_IDX_BITS'(15);

   typedef struct packed {
      logic        hit;
      logic [5:0]  set_index;
      logic [2:0]  way_index;
      logic        evicted;
      logic [15:0] evicted_block;
   } lookup_result_type;

   typedef enum bit [1:0] {ROW_ACCESS, ROW_CHECKED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] data;
      logic [15:0]              blk;
      lookup_result_type        res;
   } step_row_type;

   step_row_type dir_rows [24] = '{
      '{ROW_CHECKED, CSR_SET_COUNT, 7'd0, 16'd0,     '{1'b0, 6'd0,  3'd0, 1'b0, 16'd0}},
      '{ROW_CHECKED, CSR_SET_COUNT, 7'd0, 16'd0,     '{1'b1, 6'd0,  3'd0, 1'b0, 16'd0}},
      '{ROW_CHECKED, CSR_SET_COUNT, 7'd0, 16'hFFFF,  '{1'b0, 6'd63, 3'd0, 1'b0, 16'd0}},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd64,    '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd128,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd192,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd256,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd320,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd384,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd448,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd0,     '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd512,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd128,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd576,   '0},
      '{ROW_CSR,     CSR_SET_COUNT, 7'd0, 16'd0,     '0},
      '{ROW_CSR,     CSR_WAY_COUNT, 7'd0, 16'd0,     '0},
      '{ROW_CHECKED, CSR_SET_COUNT, 7'd0, 16'd7,     '{1'b0, 6'd0,  3'd0, 1'b1, 16'd0}},
      '{ROW_CHECKED, CSR_SET_COUNT, 7'd0, 16'd9,     '{1'b0, 6'd0,  3'd0, 1'b1, 16'd7}},
      '{ROW_CSR,     CSR_SET_COUNT, 7'h7F, 16'd0,    '0},
      '{ROW_CSR,     CSR_WAY_COUNT, 7'h7F, 16'd0,    '0},
      '{ROW_CSR,     CSR_SPARE,     7'h7F, 16'd0,    '0},
      '{ROW_CHECKED, CSR_SET_COUNT, 7'd0, 16'd9,     '{1'b0, 6'd9,  3'd0, 1'b0, 16'd0}},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'd448,   '0},
      '{ROW_ACCESS,  CSR_SET_COUNT, 7'd0, 16'hAAAA,  '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   slc_req_if #(.BLOCK_BITS(16)) req_if ();
   slc_rsp_if #(.BLOCK_BITS(16), .SET_BITS(6), .WAY_BITS(3)) rsp_if ();
   slc_csr_if csr_if ();

   set_assoc_lru_cache_lookup u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // tag store model
   logic [15:0]              tag_block [N_SETS*N_WAYS];
   logic                     tag_valid [N_SETS*N_WAYS];
   logic [31:0]              tag_stamp [N_SETS*N_WAYS];
   logic [31:0]              access_stamp;
   logic [SET_CNT_BITS-1:0]  set_cfg;
   logic [WAY_CNT_BITS-1:0]  way_cfg;

   lookup_result_type pending_results [$];
   int                err_count;
   int                burst_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("** set_assoc_lru_cache_lookup: FAILED **");
      $finish;
   end

   function automatic int unsigned eff_sets();
      if (set_cfg == 0) return 1;
      if (set_cfg > N_SETS) return N_SETS;
      return set_cfg;
   endfunction

   function automatic int unsigned eff_ways();
      if (way_cfg == 0) return 1;
      if (way_cfg > N_WAYS) return N_WAYS;
      return way_cfg;
   endfunction

   function automatic lookup_result_type predict_lookup(input logic [15:0] blk);
      int unsigned       base, w, hit_way, empty_way, victim, chosen;
      bit                found, have_empty, have_victim;
      logic [31:0]       victim_stamp;
      lookup_result_type res;
      res = '0;
      found = 0;
      have_empty = 0;
      have_victim = 0;
      hit_way = 0;
      empty_way = 0;
      victim = 0;
      victim_stamp = '0;
      res.set_index = 6'(blk % eff_sets());
      base = res.set_index * N_WAYS;
      for (w = 0; w < eff_ways(); w++) begin
         if (tag_valid[base+w]) begin
            if (!found && tag_block[base+w] == blk) begin
               found = 1;
               hit_way = w;
            end
            if (!have_victim || tag_stamp[base+w] < victim_stamp) begin
               have_victim = 1;
               victim = w;
               victim_stamp = tag_stamp[base+w];
            end
         end else if (!have_empty) begin
            have_empty = 1;
            empty_way = w;
         end
      end
      if (found) begin
         chosen = hit_way;
      end else begin
         if (have_empty) begin
            chosen = empty_way;
         end else begin
            chosen = victim;
            res.evicted = 1'b1;
            res.evicted_block = tag_block[base+chosen];
         end
         tag_block[base+chosen] = blk;
         tag_valid[base+chosen] = 1'b1;
      end
      tag_stamp[base+chosen] = access_stamp;
      if (access_stamp != '1) access_stamp = access_stamp + 1;
      res.hit = found;
      res.way_index = 3'(chosen);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      err_count++;
   endtask

   // hold off new lookups until every outstanding response is back
   task automatic drain_lookups();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      drain_lookups();
      csr_if.valid    <= 1'b1;
      csr_if.wr_index <= idx;
      csr_if.wr_data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (idx == CSR_SET_COUNT) set_cfg = data;
      else if (idx == CSR_WAY_COUNT) way_cfg = data[WAY_CNT_BITS-1:0];
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_lookup(input logic [15:0] blk, input bit typed,
                              input lookup_result_type typed_res);
      int                gap;
      lookup_result_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_if.valid        <= 1'b1;
      req_if.block_number <= blk;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      res = predict_lookup(blk);
      pending_results.push_back(typed ? typed_res : res);
      burst_left--;
      @(negedge clock);
   endtask

   // response side: ready runs broken by short or occasionally long stalls
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         rsp_if.ready <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
            @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_beat
      lookup_result_type got, want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = '{rsp_if.hit, rsp_if.set_index, rsp_if.way_index, rsp_if.evicted,
                 rsp_if.evicted_block};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", 32'(got), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit)
               report_mismatch("hit", 32'(got.hit), 32'(want.hit));
            if (got.set_index !== want.set_index)
               report_mismatch("set_index", 32'(got.set_index), 32'(want.set_index));
            if (got.way_index !== want.way_index)
               report_mismatch("way_index", 32'(got.way_index), 32'(want.way_index));
            if (got.evicted !== want.evicted)
               report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
            if (got.evicted_block !== want.evicted_block)
               report_mismatch("evicted_block", 32'(got.evicted_block),
                               32'(want.evicted_block));
         end
      end
   end

   initial begin
      int unsigned              p, i, span;
      logic [CSR_DATA_BITS-1:0] sc, wc;
      logic [15:0]              blk_base, blk;
      req_if.valid        = 1'b0;
      req_if.block_number = '0;
      csr_if.valid        = 1'b0;
      csr_if.wr_index     = '0;
      csr_if.wr_data      = '0;
      err_count    = 0;
      burst_left   = 0;
      access_stamp = 32'd1;
      set_cfg      = SET_COUNT_RST;
      way_cfg      = WAY_COUNT_RST;
      blk_base     = '0;
      foreach (tag_valid[k]) begin
         tag_valid[k] = 1'b0;
         tag_block[k] = '0;
         tag_stamp[k] = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[r]) begin
         case (dir_rows[r].kind)
            ROW_CSR:     write_csr(dir_rows[r].idx, dir_rows[r].data);
            ROW_CHECKED: send_lookup(dir_rows[r].blk, 1'b1, dir_rows[r].res);
            default:     send_lookup(dir_rows[r].blk, 1'b0, '0);
         endcase
      end

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin sc = 7'd64;  wc = 7'd8;  end
            1: begin sc = 7'd1;   wc = 7'd1;  end
            2: begin sc = 7'd1;   wc = 7'd8;  end
            3: begin sc = 7'd64;  wc = 7'd1;  end
            4: begin sc = 7'd0;   wc = 7'd0;  end
            5: begin sc = 7'h7F;  wc = 7'h7F; end
            default: begin
               sc = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
               wc = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
            end
         endcase
         write_csr(CSR_SET_COUNT, sc);
         write_csr(CSR_WAY_COUNT, wc);
         if ($urandom_range(0, 2) == 0)
            write_csr(CSR_IDX_BITS'($urandom_range(2, 15)), 7'($urandom));
         if (p % 3 == 0) blk_base = 16'($urandom);
         span = eff_sets() * (eff_ways() + 2);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 15) blk = 16'($urandom);
            else blk = blk_base + 16'($urandom_range(0, span));
            send_lookup(blk, 1'b0, '0);
            if (p == 3 && i == 60) drain_lookups();
         end
      end

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (err_count == 0)
         $display("** set_assoc_lru_cache_lookup: PASSED **");
      else
         $display("** set_assoc_lru_cache_lookup: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/slc_pkg.sv
sv/slc_chan_if.sv
sv/slc_mod_unit.sv
sv/set_assoc_lru_cache_lookup.sv
tb/tb_top.sv
